/* src/sefd_pkg.sv */
package sefd_pkg;

	localparam logic [7:0]  START_BYTE_RST    = 8'd2;
	localparam logic [7:0]  END_BYTE_RST      = 8'd3;
	localparam logic [11:0] MAX_FRAME_LEN_RST = 12'd1024;

	localparam logic [11:0] HDR_LEN_CHARS = 12'd4;
	localparam logic [11:0] HDR_CHARS     = 12'd6;
	localparam logic [12:0] DELIM_BYTES   = 13'd2;
	localparam logic [15:0] LEN_BIAS      = 16'd2;

	typedef enum logic [1:0] {
		CFG_START_BYTE    = 2'd0,
		CFG_END_BYTE      = 2'd1,
		CFG_MAX_FRAME_LEN = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_GOOD     = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_BAD_HEX  = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_OVERRUN  = 3'd5,
		ST_STRAY    = 3'd6
	} status_t;

	typedef struct packed {
		logic        is_end;
		logic [7:0]  body_byte;
		status_t     status;
		logic [7:0]  command;
		logic [11:0] body_length;
	} result_t;

	// {bad, value}: bad set when c is not 0-9, a-f or A-F
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
				hex_digit = {1'b0, d[3:0]};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
				hex_digit = {1'b0, d[3:0]};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
				hex_digit = {1'b0, d[3:0]};
			end else begin
				hex_digit = {1'b1, d[3:0]};
			end
		end
	endfunction

endpackage

/* src/sefd_parser.sv */
module sefd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [11:0]      cfg_data,
	input  logic             take,
	input  logic [7:0]       in_byte,
	output logic             res_valid,
	output sefd_pkg::result_t res
);
	import sefd_pkg::*;

	logic [7:0]  start_byte_q;
	logic [7:0]  end_byte_q;
	logic [11:0] max_frame_len_q;

	logic        in_frame_q, in_frame_d;
	logic [11:0] byte_count_q, byte_count_d;
	logic [15:0] declared_q, declared_d;
	logic [7:0]  command_q, command_d;
	logic        hex_error_q, hex_error_d;

	logic        produce;
	logic [12:0] frame_len;
	logic [11:0] count_inc;
	logic [4:0]  hex;
	logic        len_match;

	assign frame_len = {1'b0, byte_count_q} + DELIM_BYTES;
	assign count_inc = byte_count_q + 12'd1;
	assign hex       = hex_digit(in_byte);
	assign len_match = (declared_q == {4'd0, byte_count_q} + LEN_BIAS);

	always_comb begin
		in_frame_d   = in_frame_q;
		byte_count_d = byte_count_q;
		declared_d   = declared_q;
		command_d    = command_q;
		hex_error_d  = hex_error_q;
		produce      = 1'b0;
		res          = '0;
		if (!in_frame_q) begin
			if (in_byte == start_byte_q) begin
				in_frame_d   = 1'b1;
				byte_count_d = '0;
				declared_d   = '0;
				command_d    = '0;
				hex_error_d  = 1'b0;
			end else begin
				produce    = 1'b1;
				res.is_end = 1'b1;
				res.status = ST_STRAY;
			end
		end else if (in_byte == end_byte_q) begin
			in_frame_d      = 1'b0;
			produce         = 1'b1;
			res.is_end      = 1'b1;
			res.command     = command_q;
			res.body_length = byte_count_q;
			priority if (frame_len >= {1'b0, max_frame_len_q}) res.status = ST_TOO_LONG;
			else if (byte_count_q < HDR_CHARS)                   res.status = ST_SHORT;
			else if (hex_error_q)                                 res.status = ST_BAD_HEX;
			else if (!len_match)                                  res.status = ST_MISMATCH;
			else                                                  res.status = ST_GOOD;
		end else if (frame_len > {1'b0, max_frame_len_q}) begin
			// drop the frame; later bytes are stray until a new start
			in_frame_d      = 1'b0;
			byte_count_d    = count_inc;
			produce         = 1'b1;
			res.is_end      = 1'b1;
			res.status      = ST_OVERRUN;
			res.command     = command_q;
			res.body_length = count_inc;
		end else if (byte_count_q < HDR_CHARS) begin
			byte_count_d = count_inc;
			if (hex[4])
				hex_error_d = 1'b1;
			if (byte_count_q < HDR_LEN_CHARS)
				declared_d = {declared_q[11:0], hex[3:0]};
			else
				command_d = {command_q[3:0], hex[3:0]};
		end else begin
			byte_count_d  = count_inc;
			produce       = 1'b1;
			res.body_byte = in_byte;
			res.command   = command_q;
		end
	end

	assign res_valid = take && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= START_BYTE_RST;
			end_byte_q      <= END_BYTE_RST;
			max_frame_len_q <= MAX_FRAME_LEN_RST;
			in_frame_q      <= 1'b0;
			byte_count_q    <= '0;
			declared_q      <= '0;
			command_q       <= '0;
			hex_error_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_START_BYTE:    start_byte_q    <= cfg_data[7:0];
					CFG_END_BYTE:      end_byte_q      <= cfg_data[7:0];
					CFG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				in_frame_q   <= in_frame_d;
				byte_count_q <= byte_count_d;
				declared_q   <= declared_d;
				command_q    <= command_d;
				hex_error_q  <= hex_error_d;
			end
		end
	end

	a_body_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_end |-> in_frame_q && byte_count_q >= HDR_CHARS)
		else $error("body beat emitted inside the header");

	a_stray_outside: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_STRAY |-> !in_frame_q)
		else $error("stray status while a frame is open");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		take && !in_frame_q && in_byte == start_byte_q
		|=> in_frame_q && byte_count_q == '0 && !hex_error_q)
		else $error("start byte did not open a clean frame");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_frame_q && in_byte == end_byte_q |=> !in_frame_q)
		else $error("end byte left the frame open");

endmodule

/* src/sefd_skid.sv */
module sefd_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sefd_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sefd_pkg::result_t out_data
);
	import sefd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    advance;

	assign in_ready  = !skid_valid_q;
	assign advance   = out_ready || !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_valid)
				out_q <= in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

endmodule

/* src/stx_etx_frame_deframer.sv */
// STX/ETX deframer: takes one byte per cycle on s_* while s_tready is high and emits at most
// one beat per byte on m_*: a body beat for each byte past the six hex header characters
// (m_tuser low), or a status beat (m_tuser high) on the end byte, on an overrun, or for a byte
// seen outside a frame. The start byte and header bytes produce nothing. A byte is taken in the
// cycle it arrives and its result is registered in the output buffer before it reaches m_*; the
// frame state is one register set updated per byte. A two-entry output buffer holds one result
// while m_tready is low and keeps s_tready high; s_tready drops only with a second result waiting.
// Registers: 0 start byte, 1 end byte, 2 maximum frame length; write them only while idle.
module stx_etx_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] body_byte, [10:8] status, [18:11] command,
	                               // [30:19] body_length, [31] zero
	output logic        m_tuser    // is_end
);
	import sefd_pkg::*;

	logic    take;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign take = s_tvalid && s_tready;

	sefd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.in_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	sefd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {1'b0, out_res.body_length, out_res.command, out_res.status,
		out_res.body_byte};
	assign m_tuser = out_res.is_end;

endmodule

/* tb/stx_etx_frame_deframer_tb.sv */
module stx_etx_frame_deframer_tb;

	import sefd_pkg::*;

	localparam int NUM_SETTINGS = 8;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 150;

	// register settings walked through by the random part, one per phase
	localparam logic [7:0]  SET_START [NUM_SETTINGS] =
		'{8'h02, 8'h00, 8'hFF, 8'h7E, 8'h02, 8'h02, 8'h3C, 8'h02};
	localparam logic [7:0]  SET_END   [NUM_SETTINGS] =
		'{8'h03, 8'hFF, 8'h00, 8'h7E, 8'h03, 8'h03, 8'h3E, 8'h03};
	localparam logic [11:0] SET_MAX   [NUM_SETTINGS] =
		'{12'd1024, 12'd4095, 12'd8, 12'd40, 12'd5, 12'd0, 12'd20, 12'd1024};
	localparam int          SET_BYTES [NUM_SETTINGS] =
		'{160, 120, 100, 125, 35, 20, 100, 120};

	typedef enum int {
		FK_GOOD,
		FK_BAD_HEX,
		FK_MISMATCH,
		FK_SHORT,
		FK_NOISE,
		FK_LONG,
		FK_OPEN
	} frame_kind_t;

	class deframe_scoreboard;
		logic [7:0]  start_b;
		logic [7:0]  end_b;
		logic [11:0] max_len;
		bit          in_frame;
		logic [11:0] count;
		logic [15:0] decl_len;
		logic [7:0]  cmd;
		bit          hex_bad;
		result_t     expected_beats[$];
		int          errors;
		int          checked;

		function new();
			start_b  = START_BYTE_RST;
			end_b    = END_BYTE_RST;
			max_len  = MAX_FRAME_LEN_RST;
			in_frame = 1'b0;
			count    = '0;
			decl_len = '0;
			cmd      = '0;
			hex_bad  = 1'b0;
			errors   = 0;
			checked  = 0;
		endfunction

		static function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
			v = 4'd0;
			if (c >= "0" && c <= "9") begin
				v = c[3:0];
				return 1'b1;
			end
			// letters a-f and A-F share the low nibble 1..6
			if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
				v = c[3:0] + 4'd9;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void set_reg(input cfg_index_t idx, input logic [11:0] val);
			case (idx)
				CFG_START_BYTE:    start_b = val[7:0];
				CFG_END_BYTE:      end_b   = val[7:0];
				CFG_MAX_FRAME_LEN: max_len = val;
				default: ;
			endcase
		endfunction

		function void expect_beat(input bit end_flag, input logic [7:0] data_b,
		                          input status_t st, input logic [7:0] cmd_b,
		                          input logic [11:0] len);
			result_t r;
			r.is_end      = end_flag;
			r.body_byte   = data_b;
			r.status      = st;
			r.command     = cmd_b;
			r.body_length = len;
			expected_beats.push_back(r);
		endfunction

		function void take_byte(input logic [7:0] b);
			int         n;
			status_t    st;
			logic [3:0] d;
			if (!in_frame) begin
				if (b == start_b) begin
					in_frame = 1'b1;
					count    = '0;
					decl_len = '0;
					cmd      = '0;
					hex_bad  = 1'b0;
				end else begin
					expect_beat(1'b1, 8'h00, ST_STRAY, 8'h00, 12'd0);
				end
				return;
			end
			if (b == end_b) begin
				if (int'(count) + 2 >= int'(max_len))
					st = ST_TOO_LONG;
				else if (count < HDR_CHARS)
					st = ST_SHORT;
				else if (hex_bad)
					st = ST_BAD_HEX;
				else if (int'(decl_len) - 2 != int'(count))
					st = ST_MISMATCH;
				else
					st = ST_GOOD;
				in_frame = 1'b0;
				expect_beat(1'b1, 8'h00, st, cmd, count);
				return;
			end
			n = int'(count) + 1;
			// drop the frame once the held bytes would pass the limit
			if (n + 1 > int'(max_len)) begin
				in_frame = 1'b0;
				count    = 12'(n);
				expect_beat(1'b1, 8'h00, ST_OVERRUN, cmd, count);
				return;
			end
			if (count < HDR_CHARS) begin
				if (!hex_nibble(b, d))
					hex_bad = 1'b1;
				if (count < HDR_LEN_CHARS)
					decl_len = {decl_len[11:0], d};
				else
					cmd = {cmd[3:0], d};
				count = 12'(n);
				return;
			end
			count = 12'(n);
			expect_beat(1'b0, b, ST_GOOD, cmd, 12'd0);
		endfunction

		task report_error(input string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_beat(input logic [31:0] data, input logic flag);
			result_t want;
			checked++;
			if (expected_beats.size() == 0) begin
				report_error($sformatf("beat %0d arrived with nothing pending", checked));
				return;
			end
			want = expected_beats.pop_front();
			if (flag !== want.is_end)
				report_error($sformatf("beat %0d is_end %b, want %b", checked, flag,
					want.is_end));
			if (data[7:0] !== want.body_byte)
				report_error($sformatf("beat %0d body_byte %h, want %h", checked, data[7:0],
					want.body_byte));
			if (data[10:8] !== want.status)
				report_error($sformatf("beat %0d status %0d, want %0d", checked, data[10:8],
					want.status));
			if (data[18:11] !== want.command)
				report_error($sformatf("beat %0d command %h, want %h", checked, data[18:11],
					want.command));
			if (data[30:19] !== want.body_length)
				report_error($sformatf("beat %0d body_length %0d, want %0d", checked,
					data[30:19], want.body_length));
			if (data[31] !== 1'b0)
				report_error($sformatf("beat %0d spare bit set", checked));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	deframe_scoreboard sb = new();
	logic [7:0]        frame_bytes[$];
	int                bytes_sent = 0;
	int                tx_idle_pct = 30;
	int                rx_idle_pct = 57;
	bit                hold_req = 1'b0;

	stx_etx_frame_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [7:0] ascii_hex(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return 8'h30 + 8'(nib);
		return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] body_rand();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == sb.end_b);
		return b;
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 60) return FK_GOOD;
		if (r < 68) return FK_BAD_HEX;
		if (r < 76) return FK_MISMATCH;
		if (r < 82) return FK_SHORT;
		if (r < 88) return FK_NOISE;
		if (r < 96) return FK_LONG;
		return FK_OPEN;
	endfunction

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_bytes.push_back(s[i]);
	endtask

	task automatic build_frame(input frame_kind_t kind, input int body_n);
		logic [15:0] decl;
		logic [7:0]  cmd_v;
		logic [23:0] hdr;
		logic [7:0]  junk;
		logic [3:0]  unused;
		int          hdr_n;
		if (kind == FK_NOISE) begin
			repeat ($urandom_range(1, 3)) begin
				do
					junk = 8'($urandom_range(255));
				while (junk == sb.start_b);
				frame_bytes.push_back(junk);
			end
			return;
		end
		decl  = 16'(body_n + 8);
		if (kind == FK_MISMATCH)
			decl = decl + 16'($urandom_range(1, 65535));
		cmd_v = 8'($urandom_range(255));
		hdr   = {decl, cmd_v};
		hdr_n = 6;
		if (kind == FK_SHORT) begin
			hdr_n  = $urandom_range(0, 5);
			body_n = 0;
		end
		frame_bytes.push_back(sb.start_b);
		for (int i = 0; i < hdr_n; i++)
			frame_bytes.push_back(ascii_hex(hdr[23 - 4 * i -: 4], 1'($urandom_range(1))));
		if (kind == FK_BAD_HEX) begin
			do
				junk = 8'($urandom_range(255));
			while (deframe_scoreboard::hex_nibble(junk, unused) || junk == sb.end_b);
			frame_bytes[1 + $urandom_range(0, 5)] = junk;
		end
		repeat (body_n)
			frame_bytes.push_back(body_rand());
		// an open frame runs on into the next start byte
		if (kind != FK_OPEN)
			frame_bytes.push_back(sb.end_b);
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame_bytes();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i]);
		frame_bytes.delete();
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		// header bytes leave nothing behind, so give the pipe a few more cycles
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [11:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	initial begin
		int          base;
		int          body_n;
		int          lo;
		frame_kind_t kind;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_START_BYTE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray, good with 0xFF body, empty, bad hex, mismatch with start byte in body
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(START_BYTE_RST);
		queue_text("0009aF");
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(END_BYTE_RST);
		frame_bytes.push_back(START_BYTE_RST);
		frame_bytes.push_back(END_BYTE_RST);
		frame_bytes.push_back(START_BYTE_RST);
		queue_text("0g0800");
		frame_bytes.push_back(END_BYTE_RST);
		frame_bytes.push_back(START_BYTE_RST);
		queue_text("000800");
		frame_bytes.push_back(START_BYTE_RST);
		frame_bytes.push_back(END_BYTE_RST);
		send_frame_bytes();
		drain();

		for (int k = 0; k < NUM_SETTINGS; k++) begin
			if (k == 3) begin
				tx_idle_pct = 57;
				rx_idle_pct = 30;
			end
			if (k == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(CFG_START_BYTE, {4'h0, SET_START[k]});
			write_reg(CFG_END_BYTE, {4'h0, SET_END[k]});
			write_reg(CFG_MAX_FRAME_LEN, SET_MAX[k]);
			if (k == NUM_SETTINGS - 1) begin
				// hold the receiver while a long frame streams in
				@(posedge clk);
				hold_req = 1'b1;
				build_frame(FK_GOOD, 80);
				send_frame_bytes();
			end
			base = bytes_sent;
			while (bytes_sent - base < SET_BYTES[k]) begin
				kind = pick_kind();
				if (kind == FK_LONG) begin
					if (sb.max_len <= 12'd64) begin
						lo     = (sb.max_len > 12'd16) ? int'(sb.max_len) - 16 : 0;
						body_n = $urandom_range(lo, int'(sb.max_len) + 2);
					end else begin
						body_n = $urandom_range(30, 60);
					end
				end else if ($urandom_range(19) == 0) begin
					body_n = $urandom_range(13, 40);
				end else begin
					body_n = $urandom_range(0, 12);
				end
				build_frame(kind, body_n);
				send_frame_bytes();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

/* stx_etx_frame_deframer.f */
src/sefd_pkg.sv
src/sefd_parser.sv
src/sefd_skid.sv
src/stx_etx_frame_deframer.sv
tb/stx_etx_frame_deframer_tb.sv
